/* hw/rtl/tls_pkg.sv */
// Shared types, constants and lookup functions for the traffic light sequencer.
`default_nettype none

package tls_pkg;

  localparam logic [7:0] DIGIT_TICKS_RST  = 8'd77;
  localparam logic [7:0] ORANGE_TICKS_RST = 8'd153;
  localparam logic [2:0] DIGIT_START      = 3'd6;

  typedef enum logic [0:0] {
    CFG_DIGIT_TICKS  = 1'b0,
    CFG_ORANGE_TICKS = 1'b1
  } cfg_index_t;

  typedef enum logic [2:0] {
    PH_RG   = 3'd0,
    PH_OR1  = 3'd1,
    PH_GR   = 3'd2,
    PH_OR2  = 3'd3,
    PH_RR   = 3'd4,
    PH_RO   = 3'd5,
    PH_HALT = 3'd6
  } phase_t;

  typedef struct packed {
    logic button_one;
    logic button_two;
  } tick_t;

  typedef struct packed {
    logic       red_one;
    logic       orange_one;
    logic       green_one;
    logic       red_two;
    logic       orange_two;
    logic       green_two;
    logic [6:0] segments;
    logic [2:0] phase_code;
  } lamp_t;

  typedef struct packed {
    logic [7:0] digit_ticks;
    logic [7:0] orange_ticks;
  } cfg_t;

  typedef struct packed {
    phase_t     phase;
    logic [7:0] tick_count;
    logic [2:0] digit_index;
    logic       request_one;
    logic       request_two;
    logic [6:0] display_pattern;
  } seq_state_t;

  // bit0 a .. bit6 g
  function automatic logic [6:0] digit_pattern(input logic [2:0] idx);
    logic [6:0] pat;
    case (idx)
      3'd0:    pat = 7'h3f;
      3'd1:    pat = 7'h06;
      3'd2:    pat = 7'h5b;
      3'd3:    pat = 7'h4f;
      3'd4:    pat = 7'h66;
      3'd5:    pat = 7'h6d;
      3'd6:    pat = 7'h7d;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

  // {green_two, orange_two, red_two, green_one, orange_one, red_one}
  function automatic logic [5:0] lamp_bits(input phase_t p);
    logic [5:0] lamps;
    case (p)
      PH_RG:   lamps = 6'h21;
      PH_OR1:  lamps = 6'h12;
      PH_GR:   lamps = 6'h0c;
      PH_OR2:  lamps = 6'h12;
      PH_RR:   lamps = 6'h09;
      default: lamps = 6'h11;
    endcase
    return lamps;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/tls_step.sv */
// Next-state and result logic for one timer tick.
`default_nettype none

module tls_step
  import tls_pkg::*;
(
  input  cfg_t       cfg,
  input  seq_state_t state,
  input  tick_t      tick,
  output seq_state_t state_next,
  output lamp_t      result
);

  always_comb begin
    phase_t     p;
    logic       countdown;
    logic [5:0] lamps;
    logic [7:0] limit;
    logic [8:0] next_count;

    p = state.phase;
    if (state.phase > PH_HALT) begin
      p = PH_HALT;
    end
    countdown = (p == PH_RG) || (p == PH_GR) || (p == PH_RR);

    state_next = state;
    if (countdown) begin
      state_next.display_pattern = digit_pattern(state.digit_index);
    end
    state_next.request_one = state.request_one | tick.button_one;
    state_next.request_two = state.request_two | tick.button_two;

    limit = countdown ? cfg.digit_ticks : cfg.orange_ticks;
    if (limit == 8'd0) begin
      limit = 8'd1;
    end
    next_count = {1'b0, state.tick_count} + 9'd1;

    if (p == PH_HALT) begin
      state_next.phase      = PH_HALT;
      state_next.tick_count = 8'd0;
    end else if (next_count >= {1'b0, limit}) begin
      state_next.tick_count = 8'd0;
      if (countdown && state.digit_index != 3'd0 && state.digit_index <= DIGIT_START) begin
        state_next.digit_index = state.digit_index - 3'd1;
      end else begin
        state_next.digit_index = DIGIT_START;
        unique case (p)
          PH_RG:   state_next.phase = PH_OR1;
          PH_OR1:  state_next.phase = PH_GR;
          PH_GR:   state_next.phase = PH_OR2;
          PH_OR2:  state_next.phase = (state_next.request_one | state_next.request_two)
                                      ? PH_RR : PH_RG;
          PH_RR:   state_next.phase = PH_RO;
          default: state_next.phase = PH_HALT;
        endcase
      end
    end else begin
      state_next.tick_count = next_count[7:0];
      state_next.phase      = p;
    end

    lamps             = lamp_bits(p);
    result.red_one    = lamps[0];
    result.orange_one = lamps[1];
    result.green_one  = lamps[2];
    result.red_two    = lamps[3];
    result.orange_two = lamps[4];
    result.green_two  = lamps[5];
    result.segments   = state_next.display_pattern;
    result.phase_code = 3'(p);
  end

endmodule

`default_nettype wire

/* hw/rtl/tls_core.sv */
// Sequencer state registers and the registered result stage.
`default_nettype none

module tls_core
  import tls_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  logic  step_valid,
  input  tick_t step,
  output logic  take,
  output logic  lamp_valid,
  input  logic  lamp_stall,
  output lamp_t lamp
);

  seq_state_t state;
  seq_state_t state_next;
  lamp_t      result;

  tls_step u_step (
    .cfg        (cfg),
    .state      (state),
    .tick       (step),
    .state_next (state_next),
    .result     (result)
  );

  assign take = step_valid && (!lamp_valid || !lamp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state.phase           <= PH_RG;
      state.tick_count      <= 8'd0;
      state.digit_index     <= DIGIT_START;
      state.request_one     <= 1'b0;
      state.request_two     <= 1'b0;
      state.display_pattern <= 7'd0;
    end else if (take) begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lamp_valid <= 1'b0;
    end else if (take) begin
      lamp_valid <= 1'b1;
    end else if (!lamp_stall) begin
      lamp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      lamp <= result;
    end
  end

  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    (state.phase == PH_HALT) |=> (state.phase == PH_HALT))
    else $error("halt left");

  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (lamp_valid && lamp_stall) |=> $stable(state))
    else $error("state moved while result stalled");

  a_phase_change_clears: assert property (@(posedge clk) disable iff (rst)
    (take && state_next.phase != state.phase) |-> (state_next.tick_count == 8'd0))
    else $error("tick count not cleared on phase change");

  a_countdown_lit: assert property (@(posedge clk) disable iff (rst)
    (lamp_valid && (lamp.phase_code == 3'(PH_RG) || lamp.phase_code == 3'(PH_GR)
                    || lamp.phase_code == 3'(PH_RR))) |-> (lamp.segments != 7'd0))
    else $error("countdown display dark");

endmodule

`default_nettype wire

/* hw/rtl/traffic_light_sequencer.sv */
// Top level of the two-way traffic light sequencer.
//
// Input channel tick/tick_valid/tick_stall: one item per timer tick, carrying
// the two request button levels. Output channel lamp/lamp_valid/lamp_stall:
// one item per tick, giving the lamps, display pattern and phase of that tick.
// An item passes an input register and then the sequencer logic, whose result
// is registered in the result register, which presents it to the receiver.
// One tick is taken every cycle while the receiver does not stall; the single
// result register is the limit, refilled in the same cycle it is emptied.
// When the receiver stalls, the result register holds and the input register
// fills; tick_stall rises once both are occupied, and no state advances.
// Configuration: cfg_we, cfg_index (0 digit_ticks, 1 orange_ticks), cfg_data,
// written while idle. Reset sets 77 and 153 ticks, phase red/green, countdown
// at six, latches clear, display dark, and empties both registers.
`default_nettype none

module traffic_light_sequencer
  import tls_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [0:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       tick_valid,
  output logic       tick_stall,
  input  tick_t      tick,
  output logic       lamp_valid,
  input  logic       lamp_stall,
  output lamp_t      lamp
);

  cfg_t  cfg;
  logic  held_valid;
  tick_t held;
  logic  take;
  logic  accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.digit_ticks  <= DIGIT_TICKS_RST;
      cfg.orange_ticks <= ORANGE_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_DIGIT_TICKS:  cfg.digit_ticks  <= cfg_data;
        CFG_ORANGE_TICKS: cfg.orange_ticks <= cfg_data;
        default:          cfg.digit_ticks  <= cfg.digit_ticks;
      endcase
    end
  end

  assign tick_stall = held_valid && !take;
  assign accept     = tick_valid && !tick_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (accept) begin
      held_valid <= 1'b1;
    end else if (take) begin
      held_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held <= tick;
    end
  end

  tls_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .step_valid (held_valid),
    .step       (held),
    .take       (take),
    .lamp_valid (lamp_valid),
    .lamp_stall (lamp_stall),
    .lamp       (lamp)
  );

endmodule

`default_nettype wire
